>>> hdl/lcbm_pkg.sv
// lcbm_pkg: shared types and constants for the latched tile-bank mapper
// no dependencies; every other file in hdl/ refers to it by scoped names
package lcbm_pkg;

    localparam int unsigned WORK_RAM_DEPTH = 8192;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam int unsigned OPCODE_W    = 2;
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned ROM_ADDR_W  = 17;
    localparam int unsigned PRG_SIZE_W  = 4;
    localparam int unsigned PRG_BANK_W  = 4;
    localparam int unsigned TILE_BANK_W = 5;
    localparam int unsigned NUM_TILE_BANKS = 4;
    localparam int unsigned OFF_W       = 15;

    localparam logic [PRG_SIZE_W-1:0] PRG_SIZE_RESET = 4'd8;

    // cpu address map
    localparam logic [ADDR_W-1:0] ADDR_WRAM      = 16'h6000;
    localparam logic [ADDR_W-1:0] ADDR_PRG_SW    = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_PRG_FIX   = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_TILE_REGS = 16'hB000;
    localparam logic [ADDR_W-1:0] ADDR_MIRR_REG  = 16'hF000;

    // ppu pattern space and latch trigger addresses
    localparam logic [ADDR_W-1:0] ADDR_PAT_END = 16'h2000;
    localparam logic [ADDR_W-1:0] ADDR_LO_FD   = 16'h0FD8;
    localparam logic [ADDR_W-1:0] ADDR_LO_FE   = 16'h0FE8;
    localparam logic [ADDR_W-1:0] ADDR_HI_FD   = 16'h1FD8;
    localparam logic [ADDR_W-1:0] ADDR_HI_FE   = 16'h1FE8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CPU_RD = 2'd0,
        OP_CPU_WR = 2'd1,
        OP_PPU_RD = 2'd2,
        OP_PPU_WR = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_RAM  = 2'd0,
        KIND_PRG  = 2'd1,
        KIND_CHR  = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_RAM_RD,
        ACT_RAM_WR,
        ACT_PRG_SW,
        ACT_PRG_FIX,
        ACT_TILE_RD,
        ACT_SET_PRG,
        ACT_SET_TILE,
        ACT_SET_MIRR
    } t_act;

    // decoded command passed from front to back
    typedef struct packed {
        t_act              act;
        logic [OFF_W-1:0]  off;
        logic [DATA_W-1:0] data;
        logic [1:0]        sel;
        logic              lo_clr;
        logic              lo_set;
        logic              hi_clr;
        logic              hi_set;
    } t_cmd;

    typedef logic [NUM_TILE_BANKS-1:0][TILE_BANK_W-1:0] t_tile_banks;

endpackage

>>> hdl/lcbm_if.sv
// lcbm_if: valid/ready channel interfaces for requests, results and config
// depends on lcbm_pkg for field widths
interface lcbm_req_if;
    logic                             valid;
    logic                             ready;
    logic [lcbm_pkg::OPCODE_W-1:0]    opcode;
    logic [lcbm_pkg::ADDR_W-1:0]      address;
    logic [lcbm_pkg::DATA_W-1:0]      write_data;

    modport source (output valid, output opcode, output address, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input address, input write_data,
                    output ready);
endinterface

interface lcbm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [lcbm_pkg::KIND_W-1:0]      result_kind;
    logic [lcbm_pkg::ROM_ADDR_W-1:0]  rom_address;
    logic [lcbm_pkg::DATA_W-1:0]      read_data;
    logic                             horizontal_mirror;

    modport source (output valid, output result_kind, output rom_address,
                    output read_data, output horizontal_mirror, input ready);
    modport sink   (input valid, input result_kind, input rom_address,
                    input read_data, input horizontal_mirror, output ready);
endinterface

interface lcbm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lcbm_pkg::PRG_SIZE_W-1:0]  prg_size_16k;

    modport source (output valid, output prg_size_16k, input ready);
    modport sink   (input valid, input prg_size_16k, output ready);
endinterface

>>> hdl/latched_chr_bank_mapper_top.sv
// latched_chr_bank_mapper_top: cartridge bank mapper with tile-fetch latches
// depends on lcbm_pkg, lcbm_if, lcbm_front, lcbm_queue and lcbm_back
//
// One bus access is taken per clock on i_req and one result word leaves on o_rsp,
// in order. A word is decoded on entry, waits in a two-entry command queue and is
// executed by the back stage, which updates the bank registers and latches, reads
// or writes the single-port work ram and loads the result register: a result is
// valid once its command has been written into the queue and then executed into
// the result register. Throughput is one word per clock while o_rsp.ready holds,
// set by the back stage taking one command per cycle through the work ram port. A
// full queue drops i_req.ready; the result register frees as soon as o_rsp.ready
// takes it. Work ram contents are undefined after reset and need no clearing pass.
// Write i_cfg (program rom size) only while no access is in flight.
module latched_chr_bank_mapper_top #(
    parameter int unsigned WORK_RAM_DEPTH = lcbm_pkg::WORK_RAM_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lcbm_req_if.sink     i_req,
    lcbm_cfg_if.sink     i_cfg,
    lcbm_rsp_if.source   o_rsp
);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    lcbm_pkg::t_cmd   front_cmd;
    lcbm_pkg::t_cmd   q_cmd;

    lcbm_front #(
        .WORK_RAM_DEPTH (WORK_RAM_DEPTH)
    ) u_front (
        .i_req   (i_req),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    lcbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    lcbm_back #(
        .WORK_RAM_DEPTH (WORK_RAM_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .i_cfg   (i_cfg),
        .o_rsp   (o_rsp)
    );

endmodule

>>> hdl/lcbm_front.sv
// lcbm_front: accepts request words and decodes them into commands
// depends on lcbm_pkg and lcbm_req_if
module lcbm_front #(
    parameter int unsigned WORK_RAM_DEPTH = lcbm_pkg::WORK_RAM_DEPTH
) (
    lcbm_req_if.sink         i_req,
    input  logic             i_full,
    output logic             o_push,
    output lcbm_pkg::t_cmd   o_cmd
);

    localparam int unsigned          OFF_W  = lcbm_pkg::OFF_W;
    localparam logic [OFF_W-1:0]     RAM_D1 = OFF_W'(WORK_RAM_DEPTH);
    localparam logic [OFF_W-1:0]     RAM_D2 = OFF_W'(2 * WORK_RAM_DEPTH);

    lcbm_pkg::t_op                   op;
    logic [lcbm_pkg::ADDR_W-1:0]     addr;
    logic [OFF_W-1:0]                ram_raw;
    logic [OFF_W-1:0]                ram_m1;
    logic [OFF_W-1:0]                ram_idx;
    logic [OFF_W-1:0]                fix_off;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    assign op   = lcbm_pkg::t_op'(i_req.opcode);
    assign addr = i_req.address;

    // ram offset folded into the work ram depth, at most two subtract steps
    assign ram_raw = OFF_W'(addr - lcbm_pkg::ADDR_WRAM);
    assign ram_m1  = (ram_raw >= RAM_D2) ? ram_raw - RAM_D2 : ram_raw;
    assign ram_idx = (ram_m1 >= RAM_D1) ? ram_m1 - RAM_D1 : ram_m1;
    assign fix_off = OFF_W'(addr - lcbm_pkg::ADDR_PRG_FIX);

    always_comb begin
        o_cmd        = '0;
        o_cmd.act    = lcbm_pkg::ACT_NONE;
        o_cmd.data   = i_req.write_data;
        case (op)
            lcbm_pkg::OP_CPU_RD: begin
                if (addr < lcbm_pkg::ADDR_WRAM) begin
                    o_cmd.act = lcbm_pkg::ACT_NONE;
                end else if (addr < lcbm_pkg::ADDR_PRG_SW) begin
                    o_cmd.act = lcbm_pkg::ACT_RAM_RD;
                    o_cmd.off = ram_idx;
                end else if (addr < lcbm_pkg::ADDR_PRG_FIX) begin
                    o_cmd.act = lcbm_pkg::ACT_PRG_SW;
                    o_cmd.off = {2'b00, addr[12:0]};
                end else begin
                    o_cmd.act = lcbm_pkg::ACT_PRG_FIX;
                    o_cmd.off = fix_off;
                end
            end
            lcbm_pkg::OP_CPU_WR: begin
                if (addr < lcbm_pkg::ADDR_WRAM) begin
                    o_cmd.act = lcbm_pkg::ACT_NONE;
                end else if (addr < lcbm_pkg::ADDR_PRG_SW) begin
                    o_cmd.act = lcbm_pkg::ACT_RAM_WR;
                    o_cmd.off = ram_idx;
                end else if (addr < lcbm_pkg::ADDR_PRG_FIX) begin
                    o_cmd.act = lcbm_pkg::ACT_NONE;
                end else if (addr < lcbm_pkg::ADDR_TILE_REGS) begin
                    o_cmd.act = lcbm_pkg::ACT_SET_PRG;
                end else if (addr < lcbm_pkg::ADDR_MIRR_REG) begin
                    // 0xB000..0xEFFF map to tile bank regs 0..3
                    o_cmd.act = lcbm_pkg::ACT_SET_TILE;
                    o_cmd.sel = addr[13:12] + 2'd1;
                end else begin
                    o_cmd.act = lcbm_pkg::ACT_SET_MIRR;
                end
            end
            lcbm_pkg::OP_PPU_RD: begin
                if (addr < lcbm_pkg::ADDR_PAT_END) begin
                    o_cmd.act    = lcbm_pkg::ACT_TILE_RD;
                    o_cmd.off    = {3'b000, addr[11:0]};
                    o_cmd.sel    = {addr[12], 1'b0};
                    o_cmd.lo_clr = (addr == lcbm_pkg::ADDR_LO_FD);
                    o_cmd.lo_set = (addr == lcbm_pkg::ADDR_LO_FE);
                    o_cmd.hi_clr = (addr[15:3] == lcbm_pkg::ADDR_HI_FD[15:3]);
                    o_cmd.hi_set = (addr[15:3] == lcbm_pkg::ADDR_HI_FE[15:3]);
                end
            end
            default: begin
                o_cmd.act = lcbm_pkg::ACT_NONE;
            end
        endcase
    end

endmodule

>>> hdl/lcbm_queue.sv
// lcbm_queue: short command fifo between the decode front and the back
// depends on lcbm_pkg
module lcbm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lcbm_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output lcbm_pkg::t_cmd   o_cmd
);

    localparam int unsigned DEPTH = lcbm_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lcbm_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> hdl/lcbm_back.sv
// lcbm_back: executes commands, holds bank state, work ram and result register
// depends on lcbm_pkg, lcbm_rsp_if and lcbm_cfg_if
module lcbm_back #(
    parameter int unsigned WORK_RAM_DEPTH = lcbm_pkg::WORK_RAM_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lcbm_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    lcbm_cfg_if.sink         i_cfg,
    lcbm_rsp_if.source       o_rsp
);

    localparam int unsigned IDX_W = $clog2(WORK_RAM_DEPTH);
    localparam int unsigned ROM_W = lcbm_pkg::ROM_ADDR_W;

    logic [lcbm_pkg::DATA_W-1:0]      r_wram [WORK_RAM_DEPTH];
    logic [lcbm_pkg::DATA_W-1:0]      r_rd_data;

    logic [lcbm_pkg::PRG_SIZE_W-1:0]  r_prg_size;
    logic [lcbm_pkg::PRG_BANK_W-1:0]  r_prog_bank;
    logic [lcbm_pkg::PRG_BANK_W-1:0]  n_prog_bank;
    lcbm_pkg::t_tile_banks            r_tile_banks;
    lcbm_pkg::t_tile_banks            n_tile_banks;
    logic                             r_low_latch;
    logic                             n_low_latch;
    logic                             r_high_latch;
    logic                             n_high_latch;
    logic                             r_mirror;
    logic                             n_mirror;

    logic                             r_out_valid;
    lcbm_pkg::t_kind                  r_kind;
    lcbm_pkg::t_kind                  n_kind;
    logic [ROM_W-1:0]                 r_rom_addr;
    logic [ROM_W-1:0]                 n_rom_addr;
    logic                             r_hmirror;

    logic                             adv;
    logic [1:0]                       tile_sel;
    logic [lcbm_pkg::PRG_BANK_W-1:0]  fix_bank;
    logic [IDX_W-1:0]                 ram_idx;

    assign adv   = i_valid && (!r_out_valid || o_rsp.ready);
    assign o_pop = adv;

    assign i_cfg.ready = 1'b1;

    assign ram_idx  = i_cmd.off[IDX_W-1:0];
    // first fixed bank is 2*size-3, wrapping in four bits
    assign fix_bank = {r_prg_size[2:0], 1'b0} - 4'd3;
    assign tile_sel = i_cmd.sel[1] ? {1'b1, r_high_latch} : {1'b0, r_low_latch};

    always_comb begin
        n_prog_bank  = r_prog_bank;
        n_tile_banks = r_tile_banks;
        n_low_latch  = r_low_latch;
        n_high_latch = r_high_latch;
        n_mirror     = r_mirror;
        n_kind       = lcbm_pkg::KIND_NONE;
        n_rom_addr   = '0;
        case (i_cmd.act)
            lcbm_pkg::ACT_RAM_RD: begin
                n_kind = lcbm_pkg::KIND_RAM;
            end
            lcbm_pkg::ACT_PRG_SW: begin
                n_kind     = lcbm_pkg::KIND_PRG;
                n_rom_addr = {r_prog_bank, i_cmd.off[12:0]};
            end
            lcbm_pkg::ACT_PRG_FIX: begin
                n_kind     = lcbm_pkg::KIND_PRG;
                n_rom_addr = {fix_bank, 13'd0} + {2'b00, i_cmd.off};
            end
            lcbm_pkg::ACT_TILE_RD: begin
                n_kind     = lcbm_pkg::KIND_CHR;
                n_rom_addr = {r_tile_banks[tile_sel], i_cmd.off[11:0]};
                // latches flip after the address is formed
                if (i_cmd.lo_clr) begin
                    n_low_latch = 1'b0;
                end
                if (i_cmd.lo_set) begin
                    n_low_latch = 1'b1;
                end
                if (i_cmd.hi_clr) begin
                    n_high_latch = 1'b0;
                end
                if (i_cmd.hi_set) begin
                    n_high_latch = 1'b1;
                end
            end
            lcbm_pkg::ACT_SET_PRG: begin
                n_prog_bank = i_cmd.data[lcbm_pkg::PRG_BANK_W-1:0];
            end
            lcbm_pkg::ACT_SET_TILE: begin
                n_tile_banks[i_cmd.sel] = i_cmd.data[lcbm_pkg::TILE_BANK_W-1:0];
            end
            lcbm_pkg::ACT_SET_MIRR: begin
                n_mirror = i_cmd.data[0];
            end
            default: begin
                n_kind = lcbm_pkg::KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_size   <= lcbm_pkg::PRG_SIZE_RESET;
            r_prog_bank  <= '0;
            r_tile_banks <= '0;
            r_low_latch  <= 1'b0;
            r_high_latch <= 1'b0;
            r_mirror     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_prg_size <= i_cfg.prg_size_16k;
            end
            if (adv) begin
                r_prog_bank  <= n_prog_bank;
                r_tile_banks <= n_tile_banks;
                r_low_latch  <= n_low_latch;
                r_high_latch <= n_high_latch;
                r_mirror     <= n_mirror;
                r_out_valid  <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kind     <= n_kind;
            r_rom_addr <= n_rom_addr;
            r_hmirror  <= n_mirror;
        end
    end

    // work ram, single port, registered read
    always_ff @(posedge i_clk) begin
        if (adv && (i_cmd.act == lcbm_pkg::ACT_RAM_WR)) begin
            r_wram[ram_idx] <= i_cmd.data;
        end
        if (adv && (i_cmd.act == lcbm_pkg::ACT_RAM_RD)) begin
            r_rd_data <= r_wram[ram_idx];
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.result_kind       = r_kind;
    assign o_rsp.rom_address       = r_rom_addr;
    assign o_rsp.read_data         = (r_kind == lcbm_pkg::KIND_RAM) ? r_rd_data : '0;
    assign o_rsp.horizontal_mirror = r_hmirror;

endmodule

>>> sim/latched_chr_bank_mapper_top_test.sv
// latched_chr_bank_mapper_top_test: self-checking bench for the tile-latch bank mapper
// depends on lcbm_pkg, lcbm_if and the mapper sources in hdl/
`timescale 1ns / 1ps

import lcbm_pkg::*;

typedef struct {
    logic [KIND_W-1:0]     kind;
    logic [ROM_ADDR_W-1:0] rom_addr;
    logic [DATA_W-1:0]     data;
    logic                  mirror;
} t_bank_map_result;

class bank_map_scoreboard;
    localparam int unsigned PRG_BANK_BYTES  = 32'h2000;
    localparam int unsigned TILE_BANK_BYTES = 32'h1000;
    localparam int unsigned LATCH_SPAN      = 8;
    localparam int unsigned MAX_REPORTS     = 40;
    localparam int unsigned RAM_IDX_W       = $clog2(WORK_RAM_DEPTH);
    localparam logic [1:0] LO_FD_BANK = 2'd0;
    localparam logic [1:0] LO_FE_BANK = 2'd1;
    localparam logic [1:0] HI_FD_BANK = 2'd2;
    localparam logic [1:0] HI_FE_BANK = 2'd3;

    logic [PRG_SIZE_W-1:0]  rom_size;
    logic [PRG_BANK_W-1:0]  prog_bank;
    logic [TILE_BANK_W-1:0] tile_bank [NUM_TILE_BANKS];
    logic                   lo_latch;
    logic                   hi_latch;
    logic                   mirror;
    logic [DATA_W-1:0]      work_ram [WORK_RAM_DEPTH];
    t_bank_map_result       expected_results [$];
    int unsigned            errors;
    int unsigned            accesses;
    int unsigned            size_writes;
    int unsigned            kind_count [4];

    function new();
        rom_size  = PRG_SIZE_RESET;
        prog_bank = '0;
        foreach (tile_bank[i]) tile_bank[i] = '0;
        lo_latch  = 1'b0;
        hi_latch  = 1'b0;
        mirror    = 1'b0;
        foreach (kind_count[i]) kind_count[i] = 0;
        errors = 0;
        accesses = 0;
        size_writes = 0;
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction

    function void set_rom_size(logic [PRG_SIZE_W-1:0] size);
        rom_size = size;
        size_writes++;
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // predicts the result word of one accepted access and updates the mapper state
    function void note_access(logic [1:0] op, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] wdata);
        t_bank_map_result       r;
        int unsigned            full;
        logic [TILE_BANK_W-1:0] bank;
        logic [RAM_IDX_W-1:0]   ram_idx;
        logic [1:0]             reg_idx;
        r.kind = KIND_NONE;
        r.data = '0;
        full = 0;
        ram_idx = RAM_IDX_W'((addr - ADDR_WRAM) % WORK_RAM_DEPTH);
        reg_idx = 2'((addr - ADDR_TILE_REGS) / TILE_BANK_BYTES);
        accesses++;
        case (op)
            OP_CPU_RD: begin
                if (addr >= ADDR_WRAM && addr < ADDR_PRG_SW) begin
                    r.kind = KIND_RAM;
                    r.data = work_ram[ram_idx];
                end else if (addr >= ADDR_PRG_SW && addr < ADDR_PRG_FIX) begin
                    r.kind = KIND_PRG;
                    full = prog_bank * PRG_BANK_BYTES + (addr - ADDR_PRG_SW);
                end else if (addr >= ADDR_PRG_FIX) begin
                    // fixed banks are the last three; sizes above eight or below two wrap in 17 bits
                    r.kind = KIND_PRG;
                    full = (2 * rom_size - 3) * PRG_BANK_BYTES + (addr - ADDR_PRG_FIX);
                end
            end
            OP_CPU_WR: begin
                if (addr >= ADDR_WRAM && addr < ADDR_PRG_SW)
                    work_ram[ram_idx] = wdata;
                else if (addr >= ADDR_PRG_FIX && addr < ADDR_TILE_REGS)
                    prog_bank = wdata[PRG_BANK_W-1:0];
                else if (addr >= ADDR_TILE_REGS && addr < ADDR_MIRR_REG)
                    tile_bank[reg_idx] = wdata[TILE_BANK_W-1:0];
                else if (addr >= ADDR_MIRR_REG)
                    mirror = wdata[0];
            end
            OP_PPU_RD: begin
                if (addr < ADDR_PAT_END) begin
                    r.kind = KIND_CHR;
                    if (addr < TILE_BANK_BYTES)
                        bank = tile_bank[lo_latch ? LO_FE_BANK : LO_FD_BANK];
                    else
                        bank = tile_bank[hi_latch ? HI_FE_BANK : HI_FD_BANK];
                    full = bank * TILE_BANK_BYTES + (addr % TILE_BANK_BYTES);
                    // latches flip only after the address is formed
                    if (addr == ADDR_LO_FD)
                        lo_latch = 1'b0;
                    if (addr == ADDR_LO_FE)
                        lo_latch = 1'b1;
                    if (addr >= ADDR_HI_FD && addr < ADDR_HI_FD + LATCH_SPAN)
                        hi_latch = 1'b0;
                    if (addr >= ADDR_HI_FE && addr < ADDR_HI_FE + LATCH_SPAN)
                        hi_latch = 1'b1;
                end
            end
            default: ;
        endcase
        r.rom_addr = full[ROM_ADDR_W-1:0];
        r.mirror = mirror;
        expected_results.push_back(r);
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [ROM_ADDR_W-1:0] rom_addr,
                               logic [DATA_W-1:0] data, logic mirror_bit);
        t_bank_map_result e;
        if (expected_results.size() == 0) begin
            report("unexpected word", '0, 32'({kind, rom_addr}));
            return;
        end
        e = expected_results.pop_front();
        kind_count[e.kind]++;
        if (kind !== e.kind)
            report("result_kind", 32'(e.kind), 32'(kind));
        if (rom_addr !== e.rom_addr)
            report("rom_address", 32'(e.rom_addr), 32'(rom_addr));
        if (data !== e.data)
            report("read_data", 32'(e.data), 32'(data));
        if (mirror_bit !== e.mirror)
            report("horizontal_mirror", 32'(e.mirror), 32'(mirror_bit));
    endfunction

    function void close_out();
        if (expected_results.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, expected_results.size());
            errors += expected_results.size();
        end
    endfunction
endclass

module latched_chr_bank_mapper_top_test;
    localparam int unsigned IDLE_LIMIT     = 2000;
    localparam int unsigned ITEMS_PER_SIZE = 266;
    localparam int unsigned QUIET_TAIL     = 120;
    localparam int unsigned NUM_SIZES      = 5;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned RAM_IDX_W      = $clog2(WORK_RAM_DEPTH);
    localparam logic [PRG_SIZE_W-1:0] ROM_SIZES [NUM_SIZES] = '{4'd2, 4'd15, 4'd5, 4'd1, 4'd8};

    typedef logic [RAM_IDX_W-1:0] t_ram_idx;

    logic i_clk;
    logic i_rst_n;

    lcbm_req_if req_if();
    lcbm_cfg_if cfg_if();
    lcbm_rsp_if rsp_if();

    latched_chr_bank_mapper_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_rsp   (rsp_if)
    );

    bank_map_scoreboard sb = new();

    bit          ram_written [WORK_RAM_DEPTH];
    t_ram_idx    written_offsets [$];
    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    bit          quiet;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(99) < stall_pct) begin
            rsp_if.ready <= 1'b0;
            stall_left <= $urandom_range(4);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.set_rom_size(cfg_if.prg_size_16k);
            if (req_if.valid && req_if.ready)
                sb.note_access(req_if.opcode, req_if.address, req_if.write_data);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.result_kind, rsp_if.rom_address, rsp_if.read_data,
                                rsp_if.horizontal_mirror);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_access(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] wdata);
        t_ram_idx off;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
        if (op == OP_CPU_WR && addr >= ADDR_WRAM && addr < ADDR_PRG_SW) begin
            off = RAM_IDX_W'((addr - ADDR_WRAM) % WORK_RAM_DEPTH);
            if (!ram_written[off]) begin
                ram_written[off] = 1'b1;
                written_offsets.push_back(off);
            end
        end
        req_if.valid      <= 1'b1;
        req_if.opcode     <= op;
        req_if.address    <= addr;
        req_if.write_data <= wdata;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
    endtask

    task automatic write_rom_size(input logic [PRG_SIZE_W-1:0] size);
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.prg_size_16k <= size;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_random_access();
        int unsigned       pick;
        t_ram_idx          off;
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        pick  = $urandom_range(99);
        addr  = ADDR_W'($urandom_range(16'hFFFF));
        wdata = DATA_W'($urandom_range(8'hFF));
        op    = OP_CPU_RD;
        if (pick < 16 || (pick < 32 && written_offsets.size() == 0)) begin
            op = OP_CPU_WR;
            addr = ADDR_W'(ADDR_WRAM + $urandom_range(WORK_RAM_DEPTH - 1));
        end else if (pick < 32) begin
            // only read back ram that has been written
            addr = ADDR_WRAM
                   + ADDR_W'(written_offsets[$urandom_range(written_offsets.size() - 1)]);
        end else if (pick < 42) begin
            // bank, tile and mirroring registers
            op = OP_CPU_WR;
            addr = ADDR_W'(ADDR_PRG_FIX + $urandom_range(16'h5FFF));
        end else if (pick < 52) begin
            addr = ADDR_W'(ADDR_PRG_SW + $urandom_range(16'h7FFF));
        end else if (pick < 57) begin
            op = OPCODE_W'($urandom_range(1));
            addr = ADDR_W'($urandom_range(ADDR_WRAM - 1));
        end else if (pick < 60) begin
            op = OP_CPU_WR;
            addr = ADDR_W'(ADDR_PRG_SW + $urandom_range(16'h1FFF));
        end else if (pick < 74) begin
            op = OP_PPU_RD;
            case ($urandom_range(4))
                0: addr = ADDR_LO_FD;
                1: addr = ADDR_LO_FE;
                2: addr = ADDR_W'(ADDR_HI_FD + $urandom_range(7));
                3: addr = ADDR_W'(ADDR_HI_FE + $urandom_range(7));
                // near misses around the trigger windows
                default: addr = ADDR_W'(($urandom_range(1) ? ADDR_HI_FD : ADDR_LO_FD)
                                        + $urandom_range(31));
            endcase
        end else if (pick < 90) begin
            op = OP_PPU_RD;
            addr = ADDR_W'($urandom_range(ADDR_PAT_END - 1));
        end else if (pick < 94) begin
            op = OP_PPU_WR;
        end else begin
            op = OPCODE_W'($urandom_range(3));
            off = RAM_IDX_W'((addr - ADDR_WRAM) % WORK_RAM_DEPTH);
            if (op == OP_CPU_RD && addr >= ADDR_WRAM && addr < ADDR_PRG_SW && !ram_written[off])
                op = OP_CPU_WR;
        end
        send_access(op, addr, wdata);
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.opcode       <= OP_CPU_RD;
        req_if.address      <= '0;
        req_if.write_data   <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.prg_size_16k <= PRG_SIZE_RESET;
        gap_pct = 0;
        stall_pct = 0;
        quiet = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass under the reset rom size
        send_access(OP_CPU_WR, 16'h6000, 8'hA5);
        send_access(OP_CPU_WR, 16'h7FFF, 8'h5A);
        send_access(OP_CPU_RD, 16'h6000, 8'h00);
        send_access(OP_CPU_RD, 16'h7FFF, 8'hFF);
        send_access(OP_CPU_RD, 16'h0000, 8'h00);
        send_access(OP_CPU_WR, 16'h5FFF, 8'hFF);
        send_access(OP_CPU_RD, 16'h8000, 8'h00);
        send_access(OP_CPU_RD, 16'hFFFF, 8'h00);
        send_access(OP_CPU_WR, 16'hA000, 8'hFF);
        send_access(OP_CPU_RD, 16'h9FFF, 8'h00);
        send_access(OP_CPU_WR, 16'hB000, 8'h1F);
        send_access(OP_CPU_WR, 16'hC000, 8'h15);
        send_access(OP_CPU_WR, 16'hDFFF, 8'h0A);
        send_access(OP_CPU_WR, 16'hEFFF, 8'hFE);
        send_access(OP_CPU_WR, 16'hF000, 8'h01);
        send_access(OP_CPU_WR, 16'h8000, 8'hFF);
        send_access(OP_PPU_RD, 16'h0FE8, 8'h00);
        send_access(OP_PPU_RD, 16'h0FFF, 8'h00);
        send_access(OP_PPU_RD, 16'h0FD8, 8'h00);
        send_access(OP_PPU_RD, 16'h1FEF, 8'h00);
        send_access(OP_PPU_RD, 16'h1000, 8'h00);
        send_access(OP_PPU_RD, 16'h1FD8, 8'h00);
        send_access(OP_PPU_RD, 16'h2000, 8'h00);
        // a ppu write at a trigger address must not flip the latch
        send_access(OP_PPU_WR, 16'h1FE8, 8'h00);
        send_access(OP_PPU_RD, 16'h1FFF, 8'h00);

        for (int s = 0; s < NUM_SIZES; s++) begin
            write_rom_size(ROM_SIZES[s]);
            for (int n = 0; n < ITEMS_PER_SIZE; n++) begin
                if (n % 50 == 0) begin
                    gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
                    stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
                end
                if (s == NUM_SIZES - 1 && n >= ITEMS_PER_SIZE - QUIET_TAIL) begin
                    gap_pct = 0;
                    quiet = 1'b1;
                end
                send_random_access();
            end
        end

        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();

        $display("ran %0d accesses across %0d rom size writes, %0d ram words written",
                 sb.accesses, sb.size_writes, written_offsets.size());
        $display("results seen: %0d ram, %0d prg, %0d chr, %0d none",
                 sb.kind_count[KIND_RAM], sb.kind_count[KIND_PRG],
                 sb.kind_count[KIND_CHR], sb.kind_count[KIND_NONE]);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
